// ===== sv/rcsp_pkg.sv =====
// ----------------------------------------------------------------------------
// rcsp_pkg
// Shared constants, codes and controller/datapath interface types for the
// reference-counted slot pool.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rcsp_pkg;

	localparam int SLOTS_PER_BLOCK = 16;
	localparam int NUM_BLOCKS      = 4;
	localparam int COUNT_BITS      = 16;

	localparam int TOTAL_SLOTS = SLOTS_PER_BLOCK * NUM_BLOCKS;
	localparam int ADDR_W = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;
	localparam int BLK_W  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int OFF_W  = (SLOTS_PER_BLOCK > 1) ? $clog2(SLOTS_PER_BLOCK) : 1;
	localparam int OPEN_W = $clog2(NUM_BLOCKS + 1);

	// port field widths
	localparam int REQ_W    = 3;
	localparam int SLOT_W   = 6;
	localparam int CV_W     = 16;
	localparam int STATUS_W = 2;
	localparam int OCNT_W   = 16;
	localparam int S_TDATA_W = ((SLOT_W + CV_W + 7) / 8) * 8;
	localparam int M_TDATA_W = ((SLOT_W + OCNT_W + 7) / 8) * 8;
	localparam int M_TUSER_W = STATUS_W + 1;

	localparam logic [COUNT_BITS-1:0] CNT_FREE     = '1;
	localparam logic [COUNT_BITS-1:0] CNT_IMMORTAL = {{(COUNT_BITS-1){1'b1}}, 1'b0};

	typedef enum logic [REQ_W-1:0] {
		REQ_ALLOC   = 3'd0,
		REQ_INC     = 3'd1,
		REQ_DEC     = 3'd2,
		REQ_SET     = 3'd3,
		REQ_GET     = 3'd4,
		REQ_COLLECT = 3'd5,
		REQ_CLEAR   = 3'd6
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 2'd0,
		ST_FULL       = 2'd1,
		ST_UNASSIGNED = 2'd2,
		ST_IMMORTAL   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		AO_HOLD,
		AO_SLOT,
		AO_HINT,
		AO_ZERO,
		AO_INC
	} addr_op_t;

	typedef enum logic [1:0] {
		W_ZERO,
		W_INC,
		W_DEC,
		W_SET
	} wsel_t;

	typedef enum logic [2:0] {
		RS_HIT,
		RS_NEW,
		RS_FULL,
		RS_REF,
		RS_PEND,
		RS_EMPTY
	} res_sel_t;

	typedef struct packed {
		logic     take;
		addr_op_t addr_op;
		logic     rd_en;
		logic     wr;
		wsel_t    wsel;
		logic     set_hint;
		logic     open_block;
		logic     free_cur;
		logic     clear_all;
		logic     emit;
		res_sel_t res_sel;
		status_t  status;
		logic     last;
		logic     pend_load;
		logic     pend_clear;
	} cmd_t;

	typedef struct packed {
		req_t req;
		logic report;
		logic hint_lt_open;
		logic open_zero;
		logic open_full;
		logic is_free;
		logic is_immortal;
		logic is_zero;
		logic scan_last;
		logic pend_valid;
		logic out_free;
	} stat_t;

endpackage

// ===== sv/rcsp_ram.sv =====
// ----------------------------------------------------------------------------
// rcsp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rcsp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/rcsp_dp.sv =====
// ----------------------------------------------------------------------------
// rcsp_dp
// Datapath: count RAM with per-slot valid bits, scan address, block state,
// pending release word and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rcsp_dp import rcsp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [REQ_W-1:0]     in_req,
	input  logic [SLOT_W-1:0]    in_slot,
	input  logic [CV_W-1:0]      in_cv,
	input  logic                 cfg_we,
	input  logic                 cfg_wdata,
	input  cmd_t                 cmd,
	output stat_t                st,
	input  logic                 m_tready,
	output logic                 m_tvalid,
	output logic [M_TDATA_W-1:0] m_tdata,
	output logic [M_TUSER_W-1:0] m_tuser,
	output logic                 m_tlast
);

	req_t                  req_q;
	logic [SLOT_W-1:0]     slot_q;
	logic [CV_W-1:0]       cv_q;
	logic [ADDR_W-1:0]     addr_q;
	logic [BLK_W-1:0]      blk_q;
	logic [OFF_W-1:0]      off_q;
	logic                  addr_ok_q;
	logic [TOTAL_SLOTS-1:0] valid_q;
	logic [BLK_W-1:0]      hint_q;
	logic [OPEN_W-1:0]     open_q;
	logic                  report_q;
	logic                  pend_valid_q;
	logic [SLOT_W-1:0]     pend_slot_q;
	logic [OCNT_W-1:0]     pend_cnt_q;
	logic                  out_valid_q;
	status_t               out_status_q;
	logic [SLOT_W-1:0]     out_slot_q;
	logic [OCNT_W-1:0]     out_cnt_q;
	logic                  out_rel_q;
	logic                  out_last_q;

	logic [COUNT_BITS-1:0] ram_q;
	logic [COUNT_BITS-1:0] cnt_eff;
	logic [COUNT_BITS-1:0] wdata;
	logic                  ram_we;
	logic [ADDR_W-1:0]     ram_waddr;
	logic [COUNT_BITS-1:0] ram_wdata;
	logic [ADDR_W-1:0]     new_base;
	logic [ADDR_W:0]       scan_end;
	status_t               r_status;
	logic [SLOT_W-1:0]     r_slot;
	logic [OCNT_W-1:0]     r_cnt;
	logic                  r_rel;

	rcsp_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(TOTAL_SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.rd_en),
		.raddr (addr_q),
		.rdata (ram_q)
	);

	// slots never written since reset, clear or block open read as unassigned
	assign cnt_eff  = (valid_q[addr_q] && addr_ok_q) ? ram_q : CNT_FREE;
	assign new_base = ADDR_W'(open_q * SLOTS_PER_BLOCK);
	assign scan_end = (ADDR_W+1)'(open_q * SLOTS_PER_BLOCK);

	always_comb begin
		case (cmd.wsel)
			W_ZERO:  wdata = '0;
			W_INC:   wdata = cnt_eff + 1'b1;
			W_DEC:   wdata = cnt_eff - 1'b1;
			W_SET:   wdata = COUNT_BITS'(cv_q);
			default: wdata = '0;
		endcase
	end

	assign ram_we    = cmd.open_block || (cmd.wr && addr_ok_q);
	assign ram_waddr = cmd.open_block ? new_base : addr_q;
	assign ram_wdata = cmd.open_block ? '0 : wdata;

	always_comb begin
		st              = '0;
		st.req          = req_q;
		st.report       = report_q;
		st.hint_lt_open = OPEN_W'(hint_q) < open_q;
		st.open_zero    = open_q == '0;
		st.open_full    = open_q == OPEN_W'(NUM_BLOCKS);
		st.is_free      = cnt_eff == CNT_FREE;
		st.is_immortal  = cnt_eff == CNT_IMMORTAL;
		st.is_zero      = cnt_eff == '0;
		st.scan_last    = ({1'b0, addr_q} + 1'b1) == scan_end;
		st.pend_valid   = pend_valid_q;
		st.out_free     = !out_valid_q || m_tready;
	end

	always_comb begin
		r_status = ST_OK;
		r_slot   = '0;
		r_cnt    = '0;
		r_rel    = 1'b0;
		case (cmd.res_sel)
			RS_HIT:  r_slot = SLOT_W'(addr_q);
			RS_NEW:  r_slot = SLOT_W'(new_base);
			RS_FULL: r_status = ST_FULL;
			RS_REF: begin
				r_status = cmd.status;
				r_slot   = slot_q;
				r_cnt    = OCNT_W'(cmd.wr ? wdata : cnt_eff);
			end
			RS_PEND: begin
				r_slot = pend_slot_q;
				r_cnt  = pend_cnt_q;
				r_rel  = 1'b1;
			end
			default: r_status = ST_OK;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			hint_q       <= '0;
			open_q       <= '0;
			report_q     <= 1'b1;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				report_q <= cfg_wdata;
			end

			if (cmd.clear_all) begin
				valid_q <= '0;
				hint_q  <= '0;
				open_q  <= '0;
			end else begin
				if (cmd.open_block) begin
					for (int i = 0; i < TOTAL_SLOTS; i++) begin
						if (OPEN_W'(i / SLOTS_PER_BLOCK) == open_q) begin
							valid_q[i] <= 1'b0;
						end
					end
					valid_q[new_base] <= 1'b1;
					hint_q            <= BLK_W'(open_q);
					open_q            <= open_q + 1'b1;
				end
				if (cmd.wr && addr_ok_q) begin
					valid_q[addr_q] <= 1'b1;
				end
				if (cmd.free_cur) begin
					valid_q[addr_q] <= 1'b0;
				end
				if (cmd.set_hint) begin
					hint_q <= blk_q;
				end
			end

			if (cmd.pend_clear) begin
				pend_valid_q <= 1'b0;
			end else if (cmd.pend_load) begin
				pend_valid_q <= 1'b1;
			end

			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			req_q  <= req_t'(in_req);
			slot_q <= in_slot;
			cv_q   <= in_cv;
		end

		case (cmd.addr_op)
			AO_SLOT: begin
				addr_q    <= ADDR_W'(slot_q);
				addr_ok_q <= int'(slot_q) < TOTAL_SLOTS;
			end
			AO_HINT: begin
				addr_q    <= ADDR_W'(hint_q * SLOTS_PER_BLOCK);
				blk_q     <= hint_q;
				off_q     <= '0;
				addr_ok_q <= 1'b1;
			end
			AO_ZERO: begin
				addr_q    <= '0;
				blk_q     <= '0;
				off_q     <= '0;
				addr_ok_q <= 1'b1;
			end
			AO_INC: begin
				addr_q <= addr_q + 1'b1;
				if (off_q == OFF_W'(SLOTS_PER_BLOCK - 1)) begin
					off_q <= '0;
					blk_q <= blk_q + 1'b1;
				end else begin
					off_q <= off_q + 1'b1;
				end
			end
			default: addr_q <= addr_q;
		endcase

		if (cmd.pend_load) begin
			pend_slot_q <= SLOT_W'(addr_q);
			pend_cnt_q  <= (req_q == REQ_CLEAR) ? OCNT_W'(cnt_eff) : '0;
		end

		if (cmd.emit) begin
			out_status_q <= r_status;
			out_slot_q   <= r_slot;
			out_cnt_q    <= r_cnt;
			out_rel_q    <= r_rel;
			out_last_q   <= cmd.last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = M_TDATA_W'({out_cnt_q, out_slot_q});
	assign m_tuser  = {out_rel_q, out_status_q};
	assign m_tlast  = out_last_q;

endmodule

// ===== sv/rcsp_ctrl.sv =====
// ----------------------------------------------------------------------------
// rcsp_ctrl
// Controller: sequences request decode, count reads, slot scans and result
// words for the slot pool datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rcsp_ctrl import rcsp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  s_tvalid,
	output logic  s_tready,
	input  stat_t st,
	output cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_READ,
		S_EXAM,
		S_NEW,
		S_FLUSH
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   rel;
	logic   push;
	logic   stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign s_tready = state_q == S_IDLE;

	// scan release: collect frees zero counts, clear releases anything assigned
	assign rel   = (st.req == REQ_COLLECT) ? st.is_zero : !st.is_free;
	assign push  = rel && ((st.req == REQ_CLEAR) || st.report);
	assign stall = push && st.pend_valid && !st.out_free;

	always_comb begin
		cmd         = '0;
		cmd.addr_op = AO_HOLD;
		cmd.wsel    = W_ZERO;
		cmd.res_sel = RS_EMPTY;
		cmd.status  = ST_OK;
		state_d     = state_q;

		unique case (state_q)
			S_IDLE: begin
				cmd.take = s_tvalid;
				if (s_tvalid) begin
					state_d = S_START;
				end
			end

			S_START: begin
				unique case (st.req) inside
					REQ_ALLOC: begin
						if (st.hint_lt_open) begin
							cmd.addr_op = AO_HINT;
							state_d     = S_READ;
						end else begin
							state_d = S_NEW;
						end
					end
					REQ_INC, REQ_DEC, REQ_SET, REQ_GET: begin
						cmd.addr_op = AO_SLOT;
						state_d     = S_READ;
					end
					REQ_COLLECT, REQ_CLEAR: begin
						if (st.open_zero) begin
							state_d = S_FLUSH;
						end else begin
							cmd.addr_op = AO_ZERO;
							state_d     = S_READ;
						end
					end
					default: state_d = S_IDLE;
				endcase
			end

			S_READ: begin
				cmd.rd_en = 1'b1;
				state_d   = S_EXAM;
			end

			S_EXAM: begin
				unique case (st.req) inside
					REQ_ALLOC: begin
						if (st.is_free) begin
							if (st.out_free) begin
								cmd.wr       = 1'b1;
								cmd.wsel     = W_ZERO;
								cmd.set_hint = 1'b1;
								cmd.emit     = 1'b1;
								cmd.res_sel  = RS_HIT;
								cmd.last     = 1'b1;
								state_d      = S_IDLE;
							end
						end else if (st.scan_last) begin
							state_d = S_NEW;
						end else begin
							cmd.addr_op = AO_INC;
							state_d     = S_READ;
						end
					end
					REQ_INC, REQ_DEC, REQ_SET, REQ_GET: begin
						if (st.out_free) begin
							cmd.emit    = 1'b1;
							cmd.res_sel = RS_REF;
							cmd.last    = 1'b1;
							if (st.req == REQ_GET) begin
								cmd.status = ST_OK;
							end else if (st.is_free) begin
								cmd.status = ST_UNASSIGNED;
							end else if (st.is_immortal && st.req != REQ_SET) begin
								cmd.status = ST_IMMORTAL;
							end else begin
								cmd.status = ST_OK;
								cmd.wr     = 1'b1;
								cmd.wsel   = (st.req == REQ_INC) ? W_INC :
								             (st.req == REQ_DEC) ? W_DEC : W_SET;
							end
							state_d = S_IDLE;
						end
					end
					REQ_COLLECT, REQ_CLEAR: begin
						if (!stall) begin
							cmd.free_cur  = rel && (st.req == REQ_COLLECT);
							cmd.pend_load = push;
							if (push && st.pend_valid) begin
								cmd.emit    = 1'b1;
								cmd.res_sel = RS_PEND;
							end
							if (st.scan_last) begin
								state_d = S_FLUSH;
							end else begin
								cmd.addr_op = AO_INC;
								state_d     = S_READ;
							end
						end
					end
					default: state_d = S_IDLE;
				endcase
			end

			S_NEW: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					cmd.last = 1'b1;
					if (st.open_full) begin
						cmd.res_sel = RS_FULL;
					end else begin
						cmd.open_block = 1'b1;
						cmd.res_sel    = RS_NEW;
					end
					state_d = S_IDLE;
				end
			end

			S_FLUSH: begin
				if (st.out_free) begin
					cmd.emit       = 1'b1;
					cmd.last       = 1'b1;
					cmd.res_sel    = st.pend_valid ? RS_PEND : RS_EMPTY;
					cmd.pend_clear = 1'b1;
					cmd.clear_all  = st.req == REQ_CLEAR;
					state_d        = S_IDLE;
				end
			end

			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ===== sv/refcounted_slot_pool.sv =====
// ----------------------------------------------------------------------------
// refcounted_slot_pool - reference-counted slot pool, one request at a time.
// Increment, decrement, set, get: one count read, then the output word.
// Allocate: scans slots from the hint block, opening a new block if none is free.
// Collect, clear: scan every slot of the open blocks; each slot
// costs one RAM read and one compare. Ready again as the last word is shown.
// Reset clears valid bits so every count reads unassigned; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module refcounted_slot_pool import rcsp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_wdata,  // report_releases
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,    // slot[5:0], count_value[21:6]
	input  logic [REQ_W-1:0]     s_tuser,    // req_type[2:0]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,    // slot_out[5:0], count_out[21:6]
	output logic [M_TUSER_W-1:0] m_tuser,    // status[1:0], released[2]
	output logic                 m_tlast     // last
);

	cmd_t  cmd;
	stat_t st;

	rcsp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	rcsp_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_req    (s_tuser),
		.in_slot   (s_tdata[SLOT_W-1:0]),
		.in_cv     (s_tdata[SLOT_W+CV_W-1:SLOT_W]),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.st        (st),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	// a word is loaded only when the output register is empty or draining
	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!m_tvalid || m_tready))
		else $error("result word loaded over a held word");

	// hint always points into the open blocks
	a_hint_open: assert property (@(posedge clk) disable iff (!arst_n)
		!st.open_zero |-> st.hint_lt_open)
		else $error("hint block outside open blocks");

	// no release word left pending when a new request is taken
	a_pend_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |-> !st.pend_valid)
		else $error("pending release word at request accept");

	// count RAM is never read and written in the same cycle
	a_ram_port: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> !(cmd.wr || cmd.open_block))
		else $error("count RAM read and write collide");

endmodule
